### design/cstr_pkg.sv
// shared types and constants for the count-smaller-to-right block
// no dependencies; imported by every module of the block
package cstr_pkg;

    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 6;
    localparam int MAX_ITEMS_DEF = 64;

    // input word: one sequence element
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_word_t;

    // result word: one count per stored position
    typedef struct packed {
        logic [COUNT_W-1:0] smaller_count;
        logic               final_res;
        logic               overflowed;
    } result_word_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic                      load;
        logic                      shift;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

### design/cstr_cell.sv
// one cell of the chain: stored value, its count and an occupied bit
// depends on cstr_pkg
module cstr_cell
    import cstr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic               left_occ,
    input  logic               right_occ,
    input  logic [COUNT_W-1:0] right_count,
    output logic               occ,
    output logic [COUNT_W-1:0] count
);

    logic                      occ_reg;
    logic                      occ_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // compare with the broadcast value, take a fresh value, or shift down on drain
    always_comb
    begin
        occ_next   = occ_reg;
        count_next = count_reg;
        value_next = value_reg;
        if (cmd.shift)
        begin
            occ_next   = right_occ;
            count_next = right_count;
        end
        else if (cmd.load)
        begin
            if (occ_reg)
            begin
                if (value_reg > cmd.value)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            else if (left_occ)
            begin
                occ_next   = 1'b1;
                count_next = '0;
                value_next = cmd.value;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    // stored value, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign occ   = occ_reg;
    assign count = count_reg;

endmodule

### design/count_smaller_to_right_top.sv
// Results start in the cycle after the last word is taken, then one word per cycle unless stalled.
// Throughput: one input word per cycle while collecting; during the drain of N results
// (one per cycle unless stalled) no input is taken, set by the single shift chain.
// Reset: asynchronous active low, clears all occupied bits, counts, overflow and drain.
// Depends on cstr_pkg and cstr_cell.
module count_smaller_to_right_top
    import cstr_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_word_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    logic                     drain_reg;
    logic                     drain_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     item_take;
    logic                     result_take;
    logic                     full;
    cell_cmd_t                cmd;
    logic [MAX_ITEMS-1:0]     occ;
    logic [COUNT_W-1:0]       count [MAX_ITEMS];

    assign item_stall  = drain_reg;
    assign item_take   = item_valid && !drain_reg;
    assign result_take = result_valid && !result_stall;
    assign full        = occ[MAX_ITEMS-1];

    // broadcast to the cells; a word that finds the chain full is dropped
    always_comb
    begin
        cmd.load  = item_take && !full;
        cmd.shift = result_take;
        cmd.value = item.value;
    end

    // drain and overflow flags
    always_comb
    begin
        drain_next = drain_reg;
        ovf_next   = ovf_reg;
        if (item_take)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            if (item.last)
            begin
                drain_next = 1'b1;
            end
        end
        if (result_take && result.final_res)
        begin
            drain_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
        end
    end

    // chain of cells; cell 0 is the head and feeds the result port
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic               left_occ;
            logic               right_occ;
            logic [COUNT_W-1:0] right_count;
            if (gi == 0)
            begin : g_head
                assign left_occ = 1'b1;
            end
            else
            begin : g_body
                assign left_occ = occ[gi-1];
            end
            if (gi == MAX_ITEMS-1)
            begin : g_tail
                assign right_occ   = 1'b0;
                assign right_count = '0;
            end
            else
            begin : g_inner
                assign right_occ   = occ[gi+1];
                assign right_count = count[gi+1];
            end
            cstr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_occ    (left_occ),
                .right_occ   (right_occ),
                .right_count (right_count),
                .occ         (occ[gi]),
                .count       (count[gi])
            );
        end
    endgenerate

    // result word straight from the head cell
    assign result_valid         = drain_reg && occ[0];
    assign result.smaller_count = count[0];
    assign result.final_res     = !occ[1];
    assign result.overflowed    = ovf_reg;

endmodule

### design/cstr_checker.sv
// port-level checks for the count-smaller-to-right block, bound to the top level
// depends on cstr_pkg and count_smaller_to_right_top
module cstr_checker
    import cstr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input item_word_t   item,
    input logic         result_valid,
    input logic         result_stall,
    input result_word_t result
);

    // no input word is taken while results are pending
    a_no_input_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input not stalled while results pending");

    // a last word always brings results in the next cycle
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.last) |=> result_valid)
        else $error("no result after last word");

    // the final result ends the burst
    a_final_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.final_res) |=> !result_valid)
        else $error("result valid after final word");

    // within a burst the overflow mark stays the same and results keep coming
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.final_res)
        |=> (result_valid && $stable(result.overflowed)))
        else $error("burst broken or overflow mark changed");

    // stalled result word holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind count_smaller_to_right_top cstr_checker u_cstr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### verif/count_smaller_to_right_top_tb.sv
`timescale 1ns / 1ps
// testbench for count_smaller_to_right_top: directed table, full-capacity runs, random sequences
// depends on cstr_pkg and count_smaller_to_right_top; every result word is checked in order
module count_smaller_to_right_top_tb;
    import cstr_pkg::*;

    localparam int CAPACITY    = MAX_ITEMS_DEF;
    localparam int RAND_ITEMS  = 32;
    localparam int CALM_FROM   = 20;
    localparam int STUCK_LIMIT = 4000;
    localparam int DIR_N       = 19;
    localparam int PRINT_CAP   = 40;

    // how random sequence values are drawn
    typedef enum int {
        MIX_SPREAD,
        MIX_CLUSTERED,
        MIX_EDGES
    } value_mix_t;

    // one row of the directed table; cnt holds typed counts, first position in cnt[0]
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      typed;
        logic [3:0][COUNT_W-1:0]   cnt;
    } dir_row_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    item_word_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    // shadow of the sequence held by the block
    logic signed [VALUE_W-1:0] seq_vals   [CAPACITY];
    logic [COUNT_W-1:0]        seq_counts [CAPACITY];
    int                        seq_fill    = 0;
    bit                        seq_dropped = 1'b0;

    result_word_t fresh_results    [$];
    result_word_t expected_results [$];
    result_word_t oldest_expected;

    int       errors       = 0;
    int       stuck_cycles = 0;
    int       stall_left   = 0;
    bit       calm         = 1'b0;
    dir_row_t dir_rows [DIR_N];

    count_smaller_to_right_top #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // count later smaller values; on the last word emit one result per stored position
    function automatic void absorb_value(input item_word_t w);
        result_word_t r;
        fresh_results.delete();
        if (seq_fill < CAPACITY)
        begin
            for (int i = 0; i < seq_fill; i++)
            begin
                if (seq_vals[i] > $signed(w.value))
                    seq_counts[i] = seq_counts[i] + 1'b1;
            end
            seq_vals[seq_fill]   = $signed(w.value);
            seq_counts[seq_fill] = '0;
            seq_fill++;
        end
        else
            seq_dropped = 1'b1;
        if (w.last)
        begin
            for (int i = 0; i < seq_fill; i++)
            begin
                r.smaller_count = seq_counts[i];
                r.final_res     = (i == seq_fill - 1);
                r.overflowed    = seq_dropped;
                fresh_results   = {fresh_results, r};
            end
            for (int i = 0; i < CAPACITY; i++)
                seq_counts[i] = '0;
            seq_fill    = 0;
            seq_dropped = 1'b0;
        end
    endfunction

    function automatic dir_row_t mk_row(input logic signed [VALUE_W-1:0] value,
                                        input logic last, input logic typed,
                                        input int c0, input int c1, input int c2,
                                        input int c3);
        dir_row_t row;
        row.value  = value;
        row.last   = last;
        row.typed  = typed;
        row.cnt[0] = c0[COUNT_W-1:0];
        row.cnt[1] = c1[COUNT_W-1:0];
        row.cnt[2] = c2[COUNT_W-1:0];
        row.cnt[3] = c3[COUNT_W-1:0];
        return row;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input value_mix_t mix);
        case (mix)
            MIX_SPREAD:    return $urandom;
            MIX_CLUSTERED: return int'($urandom_range(0, 7)) - 4;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return '0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP)
            $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // offer one word, wait for it to be taken, then log what it should produce
    task automatic send_word(input item_word_t w, input bit typed,
                             input logic [3:0][COUNT_W-1:0] cnt);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_value(w);
        for (int i = 0; i < fresh_results.size(); i++)
        begin
            if (typed)
            begin
                fresh_results[i].smaller_count = cnt[i];
                fresh_results[i].final_res     = (i == fresh_results.size() - 1);
                fresh_results[i].overflowed    = 1'b0;
            end
            expected_results = {expected_results, fresh_results[i]};
        end
    endtask

    task automatic send_sequence(input int len, input value_mix_t mix);
        item_word_t w;
        for (int k = 0; k < len; k++)
        begin
            w.value = pick_value(mix);
            w.last  = (k == len - 1);
            send_word(w, 1'b0, '0);
        end
    endtask

    // receiver stalls in random bursts, no new burst starts once the run turns calm
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(1, 16) - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word, count", result.smaller_count, -1);
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.smaller_count !== oldest_expected.smaller_count)
                    report_mismatch("smaller_count", result.smaller_count,
                                    oldest_expected.smaller_count);
                if (result.final_res !== oldest_expected.final_res)
                    report_mismatch("final_res", result.final_res, oldest_expected.final_res);
                if (result.overflowed !== oldest_expected.overflowed)
                    report_mismatch("overflowed", result.overflowed,
                                    oldest_expected.overflowed);
            end
        end
    end

    // watchdog on cycles with no word taken on either side
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        item_word_t w;
        int         len;
        int         sent;
        value_mix_t mix;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: single word, extremes, equal values, mixed signs, descending
        dir_rows[0]  = mk_row(32'sh80000000, 1'b1, 1'b1, 0, 0, 0, 0);
        dir_rows[1]  = mk_row(32'sh7fffffff, 1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[2]  = mk_row(32'sh80000000, 1'b1, 1'b1, 1, 0, 0, 0);
        dir_rows[3]  = mk_row(5,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[4]  = mk_row(5,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[5]  = mk_row(5,             1'b1, 1'b1, 0, 0, 0, 0);
        dir_rows[6]  = mk_row(0,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[7]  = mk_row(-1,            1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[8]  = mk_row(1,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[9]  = mk_row(-2,            1'b1, 1'b1, 2, 1, 1, 0);
        dir_rows[10] = mk_row(32'sh7fffffff, 1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[11] = mk_row(32'sh80000000, 1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[12] = mk_row(32'sh55555555, 1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[13] = mk_row(32'shaaaaaaaa, 1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[14] = mk_row(-5,            1'b1, 1'b0, 0, 0, 0, 0);
        dir_rows[15] = mk_row(3,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[16] = mk_row(2,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[17] = mk_row(1,             1'b0, 1'b0, 0, 0, 0, 0);
        dir_rows[18] = mk_row(0,             1'b1, 1'b1, 3, 2, 1, 0);
        for (int r = 0; r < DIR_N; r++)
        begin
            w.value = dir_rows[r].value;
            w.last  = dir_rows[r].last;
            send_word(w, dir_rows[r].typed, dir_rows[r].cnt);
        end

        // exactly full, strictly descending so the first count reaches its top
        for (int k = 0; k < CAPACITY; k++)
        begin
            w.value = 32'sh7fffffff - k;
            w.last  = (k == CAPACITY - 1);
            send_word(w, 1'b0, '0);
        end
        // full plus two dropped words, the last word among the dropped
        send_sequence(CAPACITY + 2, MIX_CLUSTERED);

        // hold the sender until the block has drained completely
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);

        // random sequences, mostly short, trimmed to the remaining word budget
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            calm = (sent >= CALM_FROM);
            case ($urandom_range(0, 15))
                0:       len = $urandom_range(CAPACITY - 2, CAPACITY + 3);
                1, 2:    len = $urandom_range(11, 30);
                default: len = $urandom_range(1, 10);
            endcase
            if (len > RAND_ITEMS - sent)
                len = RAND_ITEMS - sent;
            mix = value_mix_t'($urandom_range(0, 2));
            send_sequence(len, mix);
            sent += len;
        end
        item_valid <= 1'b0;

        // drain and settle
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
design/cstr_pkg.sv
design/cstr_cell.sv
design/count_smaller_to_right_top.sv
design/cstr_checker.sv
verif/count_smaller_to_right_top_tb.sv
